// ===== sv/avtd_pkg.sv =====
package avtd_pkg;

    // Field widths
    localparam int LEVEL_W    = 16;
    localparam int COUNT_W    = 16;
    localparam int FRAC_W     = 16;                 // noise floor fraction bits
    localparam int FLOOR_W    = LEVEL_W + FRAC_W;   // noise floor, Q16.16
    localparam int MULT_W     = 16;                 // Q8.8 multiplier
    localparam int MULT_FRAC  = 8;
    localparam int ALPHA_W    = 16;                 // Q0.16 alpha
    localparam int THR_SHIFT  = FRAC_W + MULT_FRAC; // floor * mult back to level units
    localparam int PROD_W     = FLOOR_W + MULT_W;
    localparam int STEP_W     = FLOOR_W + ALPHA_W;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [1:0] {
        KIND_LEVEL      = 2'd0,
        KIND_RESP_START = 2'd1,
        KIND_RESP_END   = 2'd2,
        KIND_RESET      = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_USER = 2'd1,
        PH_PROC = 2'd2,
        PH_ASST = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE       = 3'd0,
        CFG_START_THR  = 3'd1,
        CFG_END_THR    = 3'd2,
        CFG_MIN_SPEECH = 3'd3,
        CFG_HANGOVER   = 3'd4,
        CFG_BARGE_IN   = 3'd5,
        CFG_NOISE_MULT = 3'd6,
        CFG_NOISE_ALPH = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        kind_t              kind;
        logic [LEVEL_W-1:0] level;
        logic               assistant_speaking;
    } req_t;

    typedef struct packed {
        phase_t             turn_state;
        logic               speech_started;
        logic               speech_ended;
        logic               barge_in;
        logic [LEVEL_W-1:0] eff_start_level;
        logic [LEVEL_W-1:0] eff_end_level;
        logic [LEVEL_W-1:0] noise_floor_level;
    } res_t;

    typedef struct packed {
        logic               enable;
        logic               barge_en;
        logic               adaptive;
        logic [LEVEL_W-1:0] start_threshold;
        logic [LEVEL_W-1:0] end_threshold;
        logic [COUNT_W-1:0] min_speech_frames;
        logic [COUNT_W-1:0] hangover_frames;
        logic [COUNT_W-1:0] barge_in_frames;
        logic [MULT_W-1:0]  start_mult;
        logic [MULT_W-1:0]  end_mult;
        logic [ALPHA_W-1:0] rise_alpha;
        logic [ALPHA_W-1:0] fall_alpha;
    } cfg_t;

    // Register defaults: block enabled, everything else zero
    localparam cfg_t CFG_RESET = cfg_t'({1'b1, {($bits(cfg_t)-1){1'b0}}});

    typedef struct packed {
        logic [LEVEL_W-1:0] start_lvl;
        logic [LEVEL_W-1:0] stop_lvl;
    } thr_t;

    typedef struct packed {
        logic started;
        logic ended;
        logic barged;
    } evt_t;

endpackage

// ===== sv/avtd_cfg.sv =====
module avtd_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [avtd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [avtd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output avtd_pkg::cfg_t                     cfg
);

    avtd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= avtd_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (avtd_pkg::cfg_idx_t'(cfg_index))
                avtd_pkg::CFG_MODE:
                begin
                    cfg_reg.enable   <= cfg_data[0];
                    cfg_reg.barge_en <= cfg_data[1];
                    cfg_reg.adaptive <= cfg_data[2];
                end
                avtd_pkg::CFG_START_THR:
                    cfg_reg.start_threshold <= cfg_data[avtd_pkg::LEVEL_W-1:0];
                avtd_pkg::CFG_END_THR:
                    cfg_reg.end_threshold <= cfg_data[avtd_pkg::LEVEL_W-1:0];
                avtd_pkg::CFG_MIN_SPEECH:
                    cfg_reg.min_speech_frames <= cfg_data[avtd_pkg::COUNT_W-1:0];
                avtd_pkg::CFG_HANGOVER:
                    cfg_reg.hangover_frames <= cfg_data[avtd_pkg::COUNT_W-1:0];
                avtd_pkg::CFG_BARGE_IN:
                    cfg_reg.barge_in_frames <= cfg_data[avtd_pkg::COUNT_W-1:0];
                avtd_pkg::CFG_NOISE_MULT:
                begin
                    cfg_reg.start_mult <= cfg_data[15:0];
                    cfg_reg.end_mult   <= cfg_data[31:16];
                end
                avtd_pkg::CFG_NOISE_ALPH:
                begin
                    cfg_reg.rise_alpha <= cfg_data[15:0];
                    cfg_reg.fall_alpha <= cfg_data[31:16];
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/avtd_level.sv =====
module avtd_level (
    input  logic                             clk,
    input  logic                             rst_n,
    input  avtd_pkg::cfg_t                   cfg,
    input  logic                             upd,
    input  logic [avtd_pkg::LEVEL_W-1:0]     level,
    output avtd_pkg::thr_t                   thr,
    output avtd_pkg::thr_t                   hold_next,
    output logic [avtd_pkg::LEVEL_W-1:0]     floor_lvl_next
);

    // floor * Q8.8 multiplier, saturated to a level, then max with the register
    function automatic logic [avtd_pkg::LEVEL_W-1:0] eff_level(
        input logic [avtd_pkg::FLOOR_W-1:0] fl,
        input logic [avtd_pkg::MULT_W-1:0]  m,
        input logic [avtd_pkg::LEVEL_W-1:0] r
    );
        logic [avtd_pkg::PROD_W-1:0]  p;
        logic [avtd_pkg::LEVEL_W-1:0] s;
        p = avtd_pkg::PROD_W'(fl) * avtd_pkg::PROD_W'(m);
        if (|p[avtd_pkg::PROD_W-1:avtd_pkg::THR_SHIFT+avtd_pkg::LEVEL_W])
            s = '1;
        else
            s = p[avtd_pkg::THR_SHIFT+avtd_pkg::LEVEL_W-1:avtd_pkg::THR_SHIFT];
        return (s > r) ? s : r;
    endfunction

    logic [avtd_pkg::FLOOR_W-1:0] floor_reg;
    logic [avtd_pkg::FLOOR_W-1:0] floor_next;
    avtd_pkg::thr_t               hold_reg;

    logic [avtd_pkg::FLOOR_W-1:0] target;
    logic                         up;
    logic [avtd_pkg::FLOOR_W-1:0] diff;
    logic [avtd_pkg::ALPHA_W-1:0] alpha;
    logic [avtd_pkg::STEP_W-1:0]  step_prod;
    logic [avtd_pkg::FLOOR_W-1:0] step;
    logic [avtd_pkg::FLOOR_W-1:0] floor_adapt;
    logic                         adapt_en;

    always_comb
    begin
        if (cfg.adaptive)
        begin
            thr.start_lvl = eff_level(floor_reg, cfg.start_mult, cfg.start_threshold);
            thr.stop_lvl  = eff_level(floor_reg, cfg.end_mult, cfg.end_threshold);
        end
        else
        begin
            thr.start_lvl = cfg.start_threshold;
            thr.stop_lvl  = cfg.end_threshold;
        end
    end

    // Step toward the level; computed alongside the thresholds, applied after compare
    always_comb
    begin
        target    = {level, {avtd_pkg::FRAC_W{1'b0}}};
        up        = target > floor_reg;
        diff      = up ? (target - floor_reg) : (floor_reg - target);
        alpha     = up ? cfg.rise_alpha : cfg.fall_alpha;
        step_prod = avtd_pkg::STEP_W'(alpha) * avtd_pkg::STEP_W'(diff);
        // zero alpha stands for 1.0
        step      = (alpha == '0) ? diff
                                  : step_prod[avtd_pkg::STEP_W-1:avtd_pkg::ALPHA_W];
        floor_adapt = up ? (floor_reg + step) : (floor_reg - step);
    end

    assign adapt_en       = upd && cfg.adaptive && (level < thr.start_lvl);
    assign floor_next     = adapt_en ? floor_adapt : floor_reg;
    assign hold_next      = upd ? thr : hold_reg;
    assign floor_lvl_next = floor_next[avtd_pkg::FLOOR_W-1:avtd_pkg::FRAC_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= '0;
            hold_reg  <= '0;
        end
        else
        begin
            floor_reg <= floor_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

// ===== sv/avtd_turn.sv =====
module avtd_turn (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  avtd_pkg::req_t   req,
    input  avtd_pkg::cfg_t   cfg,
    input  avtd_pkg::thr_t   thr,
    output avtd_pkg::phase_t phase_next,
    output avtd_pkg::evt_t   evt
);

    function automatic logic [avtd_pkg::COUNT_W-1:0] sat_inc(
        input logic [avtd_pkg::COUNT_W-1:0] c
    );
        return (&c) ? c : c + 1'b1;
    endfunction

    avtd_pkg::phase_t             phase_reg;
    logic [avtd_pkg::COUNT_W-1:0] speech_run_reg;
    logic [avtd_pkg::COUNT_W-1:0] speech_run_next;
    logic [avtd_pkg::COUNT_W-1:0] silence_run_reg;
    logic [avtd_pkg::COUNT_W-1:0] silence_run_next;

    logic                         above_start;
    logic                         below_stop;
    logic                         barge_cond;
    logic [avtd_pkg::COUNT_W-1:0] speech_inc;
    logic [avtd_pkg::COUNT_W-1:0] silence_inc;
    logic                         start_hit;
    logic                         stop_hit;
    logic                         barge_hit;

    assign above_start = req.level >= thr.start_lvl;
    assign below_stop  = req.level < thr.stop_lvl;
    assign barge_cond  = cfg.barge_en && req.assistant_speaking && above_start;
    assign speech_inc  = sat_inc(speech_run_reg);
    assign silence_inc = sat_inc(silence_run_reg);
    assign start_hit   = above_start && (speech_inc >= cfg.min_speech_frames);
    assign stop_hit    = below_stop && (silence_inc >= cfg.hangover_frames);
    assign barge_hit   = barge_cond && (speech_inc >= cfg.barge_in_frames);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (req.kind)
            avtd_pkg::KIND_RESP_START: phase_next = avtd_pkg::PH_ASST;
            avtd_pkg::KIND_RESP_END:
                if (phase_reg == avtd_pkg::PH_ASST)
                    phase_next = avtd_pkg::PH_IDLE;
            avtd_pkg::KIND_RESET: phase_next = avtd_pkg::PH_IDLE;
            avtd_pkg::KIND_LEVEL:
                if (cfg.enable)
                begin
                    unique case (phase_reg)
                        avtd_pkg::PH_IDLE: if (start_hit) phase_next = avtd_pkg::PH_USER;
                        avtd_pkg::PH_USER: if (stop_hit) phase_next = avtd_pkg::PH_PROC;
                        avtd_pkg::PH_ASST: if (barge_hit) phase_next = avtd_pkg::PH_USER;
                        avtd_pkg::PH_PROC: ;
                    endcase
                end
        endcase
    end

    // Run counters and events
    always_comb
    begin
        speech_run_next  = speech_run_reg;
        silence_run_next = silence_run_reg;
        evt              = '0;
        if (req.kind != avtd_pkg::KIND_LEVEL)
        begin
            speech_run_next  = '0;
            silence_run_next = '0;
        end
        else if (cfg.enable)
        begin
            unique case (phase_reg)
                avtd_pkg::PH_IDLE:
                    if (above_start)
                    begin
                        speech_run_next = speech_inc;
                        if (start_hit)
                        begin
                            silence_run_next = '0;
                            evt.started      = 1'b1;
                        end
                    end
                    else
                        speech_run_next = '0;
                avtd_pkg::PH_USER:
                    if (below_stop)
                    begin
                        silence_run_next = silence_inc;
                        if (stop_hit)
                        begin
                            speech_run_next = '0;
                            evt.ended       = 1'b1;
                        end
                    end
                    else
                        silence_run_next = '0;
                avtd_pkg::PH_ASST:
                    if (barge_cond)
                    begin
                        speech_run_next = speech_inc;
                        if (barge_hit)
                        begin
                            speech_run_next  = '0;
                            silence_run_next = '0;
                            evt.barged       = 1'b1;
                            evt.started      = 1'b1;
                        end
                    end
                    else
                        speech_run_next = '0;
                avtd_pkg::PH_PROC: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= avtd_pkg::PH_IDLE;
            speech_run_reg  <= '0;
            silence_run_reg <= '0;
        end
        else if (adv)
        begin
            phase_reg       <= phase_next;
            speech_run_reg  <= speech_run_next;
            silence_run_reg <= silence_run_next;
        end
    end

endmodule

// ===== sv/adaptive_voice_turn_detector_top.sv =====
// Pipeline: an accepted request is registered in the input stage, and its result is
//   registered in the result stage once that stage is empty or being drained.
// Throughput: one request per cycle while res_ready stays high; the phase, run counters
//   and noise floor are updated as a request moves from input to result register.
// Reset: rst_n is asynchronous, active low; it returns the phase to idle, clears
//   counters, noise floor, held thresholds and both pipeline stages, and loads the
//   registers with their defaults (block enabled, all else zero).
module adaptive_voice_turn_detector_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  avtd_pkg::req_t                     req,
    output logic                               res_valid,
    input  logic                               res_ready,
    output avtd_pkg::res_t                     res,
    input  logic                               cfg_we,
    input  logic [avtd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [avtd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Input stage: holds the request whose work is done when the stage advances
    logic               s1_valid_reg;
    avtd_pkg::req_t     s1_req_reg;

    // Result stage: holds the finished result until the consumer takes it
    logic               res_valid_reg;
    avtd_pkg::res_t     res_reg;
    avtd_pkg::res_t     res_next;

    logic               adv;
    logic               upd;

    avtd_pkg::cfg_t     cfg;
    avtd_pkg::thr_t     thr;
    avtd_pkg::thr_t     hold_next;
    logic [avtd_pkg::LEVEL_W-1:0] floor_lvl_next;
    avtd_pkg::phase_t   phase_next;
    avtd_pkg::evt_t     evt;

    // Advance the input stage whenever the result stage is empty or being drained.
    // All state commits on the same edge, so the next request sees it at once.
    assign adv       = s1_valid_reg && (!res_valid_reg || res_ready);
    assign req_ready = !s1_valid_reg || adv;

    // Noise floor and held thresholds move only on level frames while enabled
    assign upd = adv && (s1_req_reg.kind == avtd_pkg::KIND_LEVEL) && cfg.enable;

    avtd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Effective thresholds, noise floor tracking, threshold hold
    avtd_level u_level (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .upd            (upd),
        .level          (s1_req_reg.level),
        .thr            (thr),
        .hold_next      (hold_next),
        .floor_lvl_next (floor_lvl_next)
    );

    // Turn phase machine with speech and silence runs
    avtd_turn u_turn (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .req        (s1_req_reg),
        .cfg        (cfg),
        .thr        (thr),
        .phase_next (phase_next),
        .evt        (evt)
    );

    always_comb
    begin
        res_next.turn_state        = phase_next;
        res_next.speech_started    = evt.started;
        res_next.speech_ended      = evt.ended;
        res_next.barge_in          = evt.barged;
        res_next.eff_start_level   = hold_next.start_lvl;
        res_next.eff_end_level     = hold_next.stop_lvl;
        res_next.noise_floor_level = floor_lvl_next;
    end

    // Control: valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
                s1_valid_reg <= req_valid;
            if (adv)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload: capture the request, and the result when the input stage advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_req_reg <= '0;
            res_reg    <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
                s1_req_reg <= req;
            if (adv)
                res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== sv/avtd_checker.sv =====
module avtd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           res_valid,
    input logic           res_ready,
    input avtd_pkg::res_t res
);

    // A start and an end never come from the same request
    a_no_start_and_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.speech_started && res.speech_ended))
        else $error("start and end flagged on one result");

    // A barge-in is a start that lands in user speaking
    a_barge_is_start: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.barge_in) |->
            (res.speech_started && res.turn_state == avtd_pkg::PH_USER))
        else $error("barge-in without start into user speaking");

    // A start always leaves the machine in user speaking
    a_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.speech_started) |-> (res.turn_state == avtd_pkg::PH_USER))
        else $error("start without user speaking phase");

    // An end always leaves the machine in processing
    a_end_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.speech_ended) |-> (res.turn_state == avtd_pkg::PH_PROC))
        else $error("end without processing phase");

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("stalled result changed");

endmodule

bind adaptive_voice_turn_detector_top avtd_checker u_avtd_checker (.*);

// ===== tb/tb_adaptive_voice_turn_detector_top.sv =====
module tb_adaptive_voice_turn_detector_top;

    // Mode register bits
    localparam logic [2:0] MODE_ENABLE = 3'b001;
    localparam logic [2:0] MODE_BARGE  = 3'b010;
    localparam logic [2:0] MODE_ADAPT  = 3'b100;
    localparam logic [2:0] MODE_ALL    = MODE_ENABLE | MODE_BARGE | MODE_ADAPT;

    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 110;
    localparam int HOLD_OFF_CYCLES = 200;
    // Longest sender gap plus longest receiver stall plus the hold-off, many times over
    localparam int STALL_LIMIT     = 3000;

    localparam int LEVEL_W = avtd_pkg::LEVEL_W;

    // Predicts the result of every accepted request and checks the results in order.
    class turn_predictor;
        avtd_pkg::phase_t                    phase;
        logic [avtd_pkg::COUNT_W-1:0]        speech_run;
        logic [avtd_pkg::COUNT_W-1:0]        silence_run;
        logic [avtd_pkg::FLOOR_W-1:0]        floor_q;
        logic [avtd_pkg::LEVEL_W-1:0]        hold_start;
        logic [avtd_pkg::LEVEL_W-1:0]        hold_end;
        avtd_pkg::cfg_t                      cfg;
        avtd_pkg::res_t                      predicted[$];
        int                                  mismatches;

        function new();
            phase       = avtd_pkg::PH_IDLE;
            speech_run  = '0;
            silence_run = '0;
            floor_q     = '0;
            hold_start  = '0;
            hold_end    = '0;
            cfg         = '0;
            cfg.enable  = 1'b1;
            mismatches  = 0;
        endfunction

        function void write_reg(avtd_pkg::cfg_idx_t idx,
                                logic [avtd_pkg::CFG_DATA_W-1:0] v);
            case (idx)
                avtd_pkg::CFG_MODE:
                    {cfg.adaptive, cfg.barge_en, cfg.enable} = v[2:0];
                avtd_pkg::CFG_START_THR:
                    cfg.start_threshold = v[avtd_pkg::LEVEL_W-1:0];
                avtd_pkg::CFG_END_THR:
                    cfg.end_threshold = v[avtd_pkg::LEVEL_W-1:0];
                avtd_pkg::CFG_MIN_SPEECH:
                    cfg.min_speech_frames = v[avtd_pkg::COUNT_W-1:0];
                avtd_pkg::CFG_HANGOVER:
                    cfg.hangover_frames = v[avtd_pkg::COUNT_W-1:0];
                avtd_pkg::CFG_BARGE_IN:
                    cfg.barge_in_frames = v[avtd_pkg::COUNT_W-1:0];
                avtd_pkg::CFG_NOISE_MULT: {cfg.end_mult, cfg.start_mult} = v;
                avtd_pkg::CFG_NOISE_ALPH: {cfg.fall_alpha, cfg.rise_alpha} = v;
                default: ;
            endcase
        endfunction

        // Larger of the register and the scaled noise floor, clipped to a level
        function logic [avtd_pkg::LEVEL_W-1:0] gate_level(
            logic [avtd_pkg::LEVEL_W-1:0] thr,
            logic [avtd_pkg::MULT_W-1:0]  mult
        );
            logic [63:0] p;
            p = (64'(floor_q) * 64'(mult)) >> avtd_pkg::THR_SHIFT;
            if (p > 64'({avtd_pkg::LEVEL_W{1'b1}}))
                p = 64'({avtd_pkg::LEVEL_W{1'b1}});
            return (p[avtd_pkg::LEVEL_W-1:0] > thr) ? p[avtd_pkg::LEVEL_W-1:0] : thr;
        endfunction

        function logic [avtd_pkg::LEVEL_W-1:0] start_gate();
            return cfg.adaptive ? gate_level(cfg.start_threshold, cfg.start_mult)
                                : cfg.start_threshold;
        endfunction

        function logic [avtd_pkg::LEVEL_W-1:0] end_gate();
            return cfg.adaptive ? gate_level(cfg.end_threshold, cfg.end_mult)
                                : cfg.end_threshold;
        endfunction

        function void track_floor(logic [avtd_pkg::LEVEL_W-1:0] lvl);
            logic [63:0] target;
            logic [63:0] gain;
            logic [63:0] span;
            logic [63:0] step;
            logic        rising;
            target = 64'(lvl) << avtd_pkg::FRAC_W;
            rising = target > 64'(floor_q);
            gain   = rising ? 64'(cfg.rise_alpha) : 64'(cfg.fall_alpha);
            if (gain == 0)
                gain = 64'd1 << avtd_pkg::ALPHA_W;
            span   = rising ? target - 64'(floor_q) : 64'(floor_q) - target;
            step   = (gain * span) >> avtd_pkg::ALPHA_W;
            floor_q = rising ? avtd_pkg::FLOOR_W'(64'(floor_q) + step)
                             : avtd_pkg::FLOOR_W'(64'(floor_q) - step);
        endfunction

        function logic [avtd_pkg::COUNT_W-1:0] bump(logic [avtd_pkg::COUNT_W-1:0] c);
            return (&c) ? c : c + 1'b1;
        endfunction

        function void note_request(avtd_pkg::req_t r);
            logic [avtd_pkg::LEVEL_W-1:0] es;
            logic [avtd_pkg::LEVEL_W-1:0] ee;
            avtd_pkg::res_t               e;
            e = '0;
            case (r.kind)
                avtd_pkg::KIND_RESP_START:
                begin
                    phase       = avtd_pkg::PH_ASST;
                    speech_run  = '0;
                    silence_run = '0;
                end
                avtd_pkg::KIND_RESP_END:
                begin
                    if (phase == avtd_pkg::PH_ASST)
                        phase = avtd_pkg::PH_IDLE;
                    speech_run  = '0;
                    silence_run = '0;
                end
                avtd_pkg::KIND_RESET:
                begin
                    phase       = avtd_pkg::PH_IDLE;
                    speech_run  = '0;
                    silence_run = '0;
                end
                avtd_pkg::KIND_LEVEL:
                begin
                    if (cfg.enable)
                    begin
                        // thresholds come from the floor as it stood before this frame
                        es = start_gate();
                        ee = end_gate();
                        if (cfg.adaptive && r.level < es)
                            track_floor(r.level);
                        hold_start = es;
                        hold_end   = ee;
                        case (phase)
                            avtd_pkg::PH_IDLE:
                            begin
                                if (r.level >= es)
                                begin
                                    speech_run = bump(speech_run);
                                    if (speech_run >= cfg.min_speech_frames)
                                    begin
                                        phase            = avtd_pkg::PH_USER;
                                        silence_run      = '0;
                                        e.speech_started = 1'b1;
                                    end
                                end
                                else
                                    speech_run = '0;
                            end
                            avtd_pkg::PH_USER:
                            begin
                                if (r.level < ee)
                                begin
                                    silence_run = bump(silence_run);
                                    if (silence_run >= cfg.hangover_frames)
                                    begin
                                        phase          = avtd_pkg::PH_PROC;
                                        speech_run     = '0;
                                        e.speech_ended = 1'b1;
                                    end
                                end
                                else
                                    silence_run = '0;
                            end
                            avtd_pkg::PH_ASST:
                            begin
                                if (cfg.barge_en && r.assistant_speaking && r.level >= es)
                                begin
                                    speech_run = bump(speech_run);
                                    if (speech_run >= cfg.barge_in_frames)
                                    begin
                                        phase            = avtd_pkg::PH_USER;
                                        speech_run       = '0;
                                        silence_run      = '0;
                                        e.barge_in       = 1'b1;
                                        e.speech_started = 1'b1;
                                    end
                                end
                                else
                                    speech_run = '0;
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
            e.turn_state        = phase;
            e.eff_start_level   = hold_start;
            e.eff_end_level     = hold_end;
            e.noise_floor_level = floor_q[avtd_pkg::FLOOR_W-1:avtd_pkg::FRAC_W];
            predicted.push_back(e);
        endfunction

        function void check_result(avtd_pkg::res_t got);
            avtd_pkg::res_t want;
            if (predicted.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: turn result with no request pending: phase=%0d flags=%b%b%b",
                             $time, got.turn_state, got.speech_started, got.speech_ended,
                             got.barge_in);
                return;
            end
            want = predicted.pop_front();
            if (got.turn_state !== want.turn_state ||
                got.speech_started !== want.speech_started ||
                got.speech_ended !== want.speech_ended ||
                got.barge_in !== want.barge_in ||
                got.eff_start_level !== want.eff_start_level ||
                got.eff_end_level !== want.eff_end_level ||
                got.noise_floor_level !== want.noise_floor_level)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: turn result mismatch: want phase=%0d st/en/bi=%b%b%b ",
                              "start=%0d end=%0d floor=%0d, got phase=%0d st/en/bi=%b%b%b ",
                              "start=%0d end=%0d floor=%0d"},
                             $time, want.turn_state, want.speech_started, want.speech_ended,
                             want.barge_in, want.eff_start_level, want.eff_end_level,
                             want.noise_floor_level, got.turn_state, got.speech_started,
                             got.speech_ended, got.barge_in, got.eff_start_level,
                             got.eff_end_level, got.noise_floor_level);
            end
        endfunction
    endclass

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  req_valid = 1'b0;
    logic                                  req_ready;
    avtd_pkg::req_t                        req = '0;
    logic                                  res_valid;
    logic                                  res_ready = 1'b0;
    avtd_pkg::res_t                        res;
    logic                                  cfg_we = 1'b0;
    logic [avtd_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [avtd_pkg::CFG_DATA_W-1:0]       cfg_data = '0;

    turn_predictor                         tracker;
    logic [avtd_pkg::CFG_DATA_W-1:0]       settings [8];
    bit                                    no_idle = 1'b0;    // both sides run without gaps
    bit                                    hold_off = 1'b0;   // receiver holds off for long
    int                                    items_sent = 0;
    int                                    quiet_cycles = 0;

    adaptive_voice_turn_detector_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Level at or above the start threshold the next frame will see; often exactly on it
    function automatic logic [LEVEL_W-1:0] loud_level();
        logic [LEVEL_W-1:0] g;
        g = tracker.start_gate();
        if ($urandom_range(0, 3) == 0)
            return g;
        return LEVEL_W'($urandom_range(int'(g), 16'hFFFF));
    endfunction

    // Level below the end threshold; none exists when that threshold is zero
    function automatic logic [LEVEL_W-1:0] quiet_level();
        logic [LEVEL_W-1:0] g;
        g = tracker.end_gate();
        if (g == 0)
            return '0;
        if ($urandom_range(0, 3) == 0)
            return g - 1'b1;
        return LEVEL_W'($urandom_range(0, int'(g) - 1));
    endfunction

    // Offer one request and hold it until accepted; then idle for a random gap.
    // With no gap, valid stays high and the next request follows at once.
    task automatic send_item(input avtd_pkg::kind_t kind, input logic [LEVEL_W-1:0] level,
                             input logic asst);
        avtd_pkg::req_t r;
        int             gap;
        r.kind               = kind;
        r.level              = level;
        r.assistant_speaking = asst;
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        tracker.note_request(r);
        items_sent++;
        gap = hold_off ? 0 : pick_gap();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain();
        req_valid <= 1'b0;
        while (tracker.predicted.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write all registers from settings; only call with the block idle
    task automatic apply_settings();
        for (int i = 0; i < $size(settings); i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= avtd_pkg::cfg_idx_t'(i);
            cfg_data  <= settings[i];
            @(posedge clk);
            tracker.write_reg(avtd_pkg::cfg_idx_t'(i), settings[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Check every result accepted at this edge against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            tracker.check_result(res);
    end

    // Watchdog: end the run if nothing moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, a long hold-off on request, high otherwise
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            if (hold_off)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                stall = pick_gap();
                if (stall != 0)
                begin
                    res_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            res_ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        int r;
        int n;
        int p;
        int target;
        int start_thr;
        tracker = new();
        foreach (settings[i])
            settings[i] = '0;
        settings[avtd_pkg::CFG_MODE] = 32'(MODE_ENABLE);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: enabled, zero thresholds and counts, so any frame starts speech
        send_item(avtd_pkg::KIND_LEVEL, 16'h0000, 1'b0);
        send_item(avtd_pkg::KIND_LEVEL, 16'hFFFF, 1'b1);
        send_item(avtd_pkg::KIND_RESET, 16'hFFFF, 1'b1);
        drain();

        // Adaptive with barge-in; rising alpha 0.25, falling alpha 1.0
        settings[avtd_pkg::CFG_MODE]       = 32'(MODE_ALL);
        settings[avtd_pkg::CFG_START_THR]  = 32'd1000;
        settings[avtd_pkg::CFG_END_THR]    = 32'd600;
        settings[avtd_pkg::CFG_MIN_SPEECH] = 32'd2;
        settings[avtd_pkg::CFG_HANGOVER]   = 32'd2;
        settings[avtd_pkg::CFG_BARGE_IN]   = 32'd2;
        settings[avtd_pkg::CFG_NOISE_MULT] = {16'h0100, 16'h0200};
        settings[avtd_pkg::CFG_NOISE_ALPH] = {16'h0000, 16'h4000};
        apply_settings();
        send_item(avtd_pkg::KIND_LEVEL, 16'd200, 1'b0);       // below start: floor creeps up
        send_item(avtd_pkg::KIND_LEVEL, 16'hFFFF, 1'b0);
        send_item(avtd_pkg::KIND_LEVEL, 16'hFFFF, 1'b0);      // second loud frame: start
        send_item(avtd_pkg::KIND_LEVEL, 16'd0, 1'b0);         // floor drops to the level
        send_item(avtd_pkg::KIND_LEVEL, 16'd900, 1'b0);       // above end: silence clears
        send_item(avtd_pkg::KIND_LEVEL, 16'd0, 1'b0);
        send_item(avtd_pkg::KIND_LEVEL, 16'd0, 1'b0);         // hangover met: processing
        send_item(avtd_pkg::KIND_LEVEL, 16'hFFFF, 1'b1);      // processing ignores frames
        send_item(avtd_pkg::KIND_RESP_END, 16'd0, 1'b0);      // not in a response
        send_item(avtd_pkg::KIND_RESP_START, 16'd0, 1'b0);
        send_item(avtd_pkg::KIND_LEVEL, 16'hFFFF, 1'b0);      // loud, assistant flag low
        send_item(avtd_pkg::KIND_LEVEL, 16'hFFFF, 1'b1);
        send_item(avtd_pkg::KIND_LEVEL, 16'hFFFF, 1'b1);      // barge-in
        send_item(avtd_pkg::KIND_RESP_START, 16'hFFFF, 1'b1);
        send_item(avtd_pkg::KIND_RESP_END, 16'hFFFF, 1'b1);   // response over: idle
        drain();

        // Disabled: frames do nothing, other kinds still act
        settings[avtd_pkg::CFG_MODE] = 32'(MODE_BARGE | MODE_ADAPT);
        apply_settings();
        send_item(avtd_pkg::KIND_LEVEL, 16'hFFFF, 1'b1);
        send_item(avtd_pkg::KIND_RESP_START, 16'd0, 1'b1);
        send_item(avtd_pkg::KIND_LEVEL, 16'hFFFF, 1'b1);
        send_item(avtd_pkg::KIND_RESET, 16'd0, 1'b0);
        drain();

        // Adaptive off: fixed thresholds, floor frozen; levels on the boundary
        settings[avtd_pkg::CFG_MODE] = 32'(MODE_ENABLE | MODE_BARGE);
        apply_settings();
        send_item(avtd_pkg::KIND_LEVEL, 16'd999, 1'b0);
        send_item(avtd_pkg::KIND_LEVEL, 16'd1000, 1'b0);
        send_item(avtd_pkg::KIND_LEVEL, 16'd1000, 1'b0);
        drain();

        // Top frame counts: the speech run climbs without reaching its limit; silence stays clear
        no_idle = 1'b1;
        settings[avtd_pkg::CFG_MODE]       = 32'(MODE_ENABLE);
        settings[avtd_pkg::CFG_START_THR]  = 32'd0;
        settings[avtd_pkg::CFG_END_THR]    = 32'hFFFF;
        settings[avtd_pkg::CFG_MIN_SPEECH] = 32'hFFFF;
        settings[avtd_pkg::CFG_HANGOVER]   = 32'hFFFF;
        apply_settings();
        send_item(avtd_pkg::KIND_RESET, 16'd0, 1'b0);
        repeat (24)
            send_item(avtd_pkg::KIND_LEVEL, LEVEL_W'($urandom_range(0, 16'hFFFE)),
                      1'($urandom_range(0, 1)));
        send_item(avtd_pkg::KIND_RESET, 16'd0, 1'b0);
        drain();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            // Default shape: reachable thresholds and short frame counts
            start_thr = $urandom_range(200, 3000);
            settings[avtd_pkg::CFG_MODE]       = 32'(MODE_ALL);
            settings[avtd_pkg::CFG_START_THR]  = start_thr;
            settings[avtd_pkg::CFG_END_THR]    = $urandom_range(50, start_thr);
            settings[avtd_pkg::CFG_MIN_SPEECH] = $urandom_range(0, 3);
            settings[avtd_pkg::CFG_HANGOVER]   = $urandom_range(0, 3);
            settings[avtd_pkg::CFG_BARGE_IN]   = $urandom_range(0, 3);
            settings[avtd_pkg::CFG_NOISE_MULT] = {16'($urandom_range(16'h80, 16'h300)),
                                                  16'($urandom_range(16'h80, 16'h300))};
            settings[avtd_pkg::CFG_NOISE_ALPH] = $urandom;
            case (p)
                1: settings[avtd_pkg::CFG_MODE] = 32'(MODE_ENABLE | MODE_BARGE);
                2: settings[avtd_pkg::CFG_MODE] = 32'(MODE_ENABLE | MODE_ADAPT);
                3: settings[avtd_pkg::CFG_MODE] = 32'(MODE_BARGE | MODE_ADAPT);
                4:
                begin
                    foreach (settings[i])
                        settings[i] = '1;
                end
                5:
                begin
                    foreach (settings[i])
                        settings[i] = '0;
                    settings[avtd_pkg::CFG_MODE] = 32'(MODE_ALL);
                end
                6:
                begin
                    // large multipliers push the scaled floor into saturation
                    settings[avtd_pkg::CFG_START_THR]  = $urandom_range(0, 300);
                    settings[avtd_pkg::CFG_END_THR]    = $urandom_range(0, 300);
                    settings[avtd_pkg::CFG_NOISE_MULT] =
                        {16'($urandom_range(16'h1000, 16'hFFFF)),
                         16'($urandom_range(16'h1000, 16'hFFFF))};
                end
                7:
                begin
                    foreach (settings[i])
                        settings[i] = $urandom;
                end
                default: ;
            endcase
            drain();
            apply_settings();
            no_idle = (p == 2);
            // First phase: receiver holds off while requests keep coming, so the block fills
            if (p == 0)
                hold_off = 1'b1;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    // utterance: loud frames then quiet ones, enough to start and end when counts are at most 6
                    n = (tracker.cfg.min_speech_frames <= 6) ?
                        int'(tracker.cfg.min_speech_frames) + $urandom_range(0, 2) :
                        $urandom_range(1, 6);
                    repeat (n)
                        send_item(avtd_pkg::KIND_LEVEL, loud_level(),
                                  1'($urandom_range(0, 1)));
                    n = (tracker.cfg.hangover_frames <= 6) ?
                        int'(tracker.cfg.hangover_frames) + $urandom_range(0, 2) :
                        $urandom_range(1, 6);
                    repeat (n)
                        send_item(avtd_pkg::KIND_LEVEL, quiet_level(),
                                  1'($urandom_range(0, 1)));
                    if ($urandom_range(0, 2) == 0)
                        send_item(avtd_pkg::KIND_RESET, LEVEL_W'($urandom), 1'($urandom));
                end
                else if (r < 75)
                begin
                    // assistant turn with user speech over it
                    send_item(avtd_pkg::KIND_RESP_START, LEVEL_W'($urandom), 1'($urandom));
                    repeat ($urandom_range(1, 6))
                        send_item(avtd_pkg::KIND_LEVEL,
                                  ($urandom_range(0, 3) != 0) ? loud_level() : quiet_level(),
                                  $urandom_range(0, 4) != 0);
                    if ($urandom_range(0, 1) != 0)
                        send_item(avtd_pkg::KIND_RESP_END, LEVEL_W'($urandom), 1'($urandom));
                end
                else if (r < 85)
                    send_item(avtd_pkg::KIND_LEVEL, LEVEL_W'($urandom), 1'($urandom));
                else
                begin
                    repeat ($urandom_range(1, 4))
                        send_item(avtd_pkg::kind_t'($urandom_range(0, 3)),
                                  LEVEL_W'($urandom), 1'($urandom));
                end
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.predicted.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
